@@ sv/ascii_integer_parser_assert.svh @@
// Assertion macros for the ascii integer parser
`ifndef ASCII_INTEGER_PARSER_ASSERT_SVH
`define ASCII_INTEGER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define AIP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("aip assertion failed");
`define AIP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("aip assertion failed");
`else
`define AIP_ASSERT_SAME(label, ante, cons)
`define AIP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/aip_pkg.sv @@
// Shared types and constants of the ascii integer parser
package aip_pkg;

    localparam int COUNT_W   = 16;
    localparam int MAX_COUNT = 65535;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    typedef enum logic [1:0] {
        MODE_AUTO = 2'd0,
        MODE_OCT  = 2'd1,
        MODE_DEC  = 2'd2,
        MODE_HEX  = 2'd3
    } base_mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_NONE     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BASE8,
        BASE10,
        BASE16
    } base_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_FIRST,
        PH_ZERO,
        PH_HEXFIRST,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        logic       start_req;
        logic [7:0] ch;
    } aip_in_t;

    typedef struct packed {
        logic signed [63:0]   value;
        logic [COUNT_W-1:0]   consumed;
        status_t              status;
    } aip_out_t;

    typedef struct packed {
        logic       start;
        logic       space;
        logic       plus;
        logic       minus;
        logic       zero;
        logic       hex_x;
        logic       dig_ok;
        logic [3:0] dig;
    } aip_cls_t;

endpackage

@@ sv/aip_front.sv @@
// Front end: accept characters and classify them for the back end
module aip_front (
    input  logic             s_valid,
    output logic             s_ready,
    input  aip_pkg::aip_in_t s_data,
    output logic             push_valid,
    input  logic             push_ready,
    output aip_pkg::aip_cls_t push_data
);
    import aip_pkg::*;

    logic [7:0] c;

    assign c          = s_data.ch;
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_data        = '0;
        push_data.start  = s_data.start_req;
        push_data.space  = (c == 8'h20) || (c == 8'h09);
        push_data.plus   = (c == 8'h2B);
        push_data.minus  = (c == 8'h2D);
        push_data.zero   = (c == 8'h30);
        push_data.hex_x  = (c == 8'h78) || (c == 8'h58);
        if (c >= 8'h30 && c <= 8'h39) begin
            push_data.dig_ok = 1'b1;
            push_data.dig    = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            push_data.dig_ok = 1'b1;
            push_data.dig    = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            push_data.dig_ok = 1'b1;
            push_data.dig    = 4'(c - 8'h37);
        end
    end

endmodule

@@ sv/aip_queue.sv @@
// Two-entry queue of classified characters between front and back
module aip_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  aip_pkg::aip_cls_t in_data,
    output logic              out_valid,
    input  logic              out_pop,
    output aip_pkg::aip_cls_t out_data
);
    import aip_pkg::*;

    aip_cls_t             entries_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ sv/aip_back.sv @@
// Back end: parse state, digit accumulation and registered result
module aip_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  aip_pkg::base_mode_t  base_mode,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  aip_pkg::aip_cls_t    q_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output aip_pkg::aip_out_t    m_data
);
    import aip_pkg::*;

    localparam logic [63:0] POS_BOUND = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_BOUND = 64'h8000_0000_0000_0000;

    phase_t             phase_reg, phase_next, phase_eff;
    logic               neg_reg, neg_next, neg_eff;
    base_t              base_reg, base_next, base_eff;
    logic [63:0]        acc_reg, acc_next, acc_eff;
    logic               ovf_reg, ovf_next, ovf_eff;
    logic [COUNT_W-1:0] cnt_reg, cnt_next, cnt_eff, cnt_bump;
    logic               m_valid_reg;
    aip_out_t           m_data_reg;

    base_t              mode_base;
    base_t              chk_base;
    logic               dig_fit;
    logic [67:0]        scaled;
    logic [67:0]        sum;
    logic [63:0]        bound;
    logic               acc_over;
    logic               emit;
    logic               emit_fail;
    logic               out_free;
    aip_out_t           result;

    function automatic logic fits(base_t b, logic [3:0] d);
        logic r;
        unique case (b)
            BASE8:   r = (d < 4'd8);
            BASE10:  r = (d < 4'd10);
            BASE16:  r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = q_valid && (!emit || out_free);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        phase_eff = q_data.start ? PH_SPACE : phase_reg;
        neg_eff   = q_data.start ? 1'b0 : neg_reg;
        base_eff  = q_data.start ? BASE10 : base_reg;
        acc_eff   = q_data.start ? '0 : acc_reg;
        ovf_eff   = q_data.start ? 1'b0 : ovf_reg;
        cnt_eff   = q_data.start ? '0 : cnt_reg;
    end

    always_comb begin
        unique case (base_mode)
            MODE_OCT: mode_base = BASE8;
            MODE_DEC: mode_base = BASE10;
            default:  mode_base = BASE16;
        endcase
        unique case (phase_eff)
            PH_SPACE, PH_FIRST: chk_base = (base_mode == MODE_AUTO) ? BASE10 : mode_base;
            PH_ZERO:            chk_base = BASE8;
            default:            chk_base = base_eff;
        endcase
        dig_fit = q_data.dig_ok && fits(chk_base, q_data.dig);

        unique case (chk_base)
            BASE8:   scaled = {acc_eff, 3'b0} + 68'd0;
            BASE10:  scaled = 68'({acc_eff, 3'b0}) + 68'({acc_eff, 1'b0});
            default: scaled = {acc_eff, 4'b0};
        endcase
        sum      = scaled + 68'(q_data.dig);
        bound    = neg_eff ? NEG_BOUND : POS_BOUND;
        acc_over = (sum > 68'(bound));
        cnt_bump = (cnt_eff == COUNT_W'(MAX_COUNT)) ? cnt_eff : cnt_eff + 1'b1;
    end

    always_comb begin
        phase_next = phase_eff;
        neg_next   = neg_eff;
        base_next  = base_eff;
        acc_next   = acc_eff;
        ovf_next   = ovf_eff;
        cnt_next   = cnt_eff;
        emit       = 1'b0;
        emit_fail  = 1'b0;
        unique case (phase_eff)
            PH_IDLE: begin
            end
            PH_SPACE, PH_FIRST: begin
                if (phase_eff == PH_SPACE && q_data.space) begin
                    cnt_next = cnt_bump;
                end else if (phase_eff == PH_SPACE && (q_data.plus || q_data.minus)) begin
                    neg_next   = q_data.minus;
                    cnt_next   = cnt_bump;
                    phase_next = PH_FIRST;
                end else if (base_mode == MODE_AUTO && q_data.zero) begin
                    base_next  = BASE10;
                    cnt_next   = cnt_bump;
                    phase_next = PH_ZERO;
                end else begin
                    base_next = chk_base;
                    if (!dig_fit) begin
                        emit       = 1'b1;
                        emit_fail  = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        acc_next   = 64'(q_data.dig);
                        cnt_next   = cnt_bump;
                        phase_next = PH_DIGITS;
                    end
                end
            end
            PH_ZERO: begin
                if (q_data.hex_x) begin
                    base_next  = BASE16;
                    cnt_next   = cnt_bump;
                    phase_next = PH_HEXFIRST;
                end else begin
                    base_next = BASE8;
                    acc_next  = '0;
                    if (!dig_fit) begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_DIGITS;
                        cnt_next   = cnt_bump;
                        if (acc_over) begin
                            ovf_next = 1'b1;
                        end else begin
                            acc_next = sum[63:0];
                        end
                    end
                end
            end
            PH_HEXFIRST: begin
                if (!dig_fit) begin
                    emit       = 1'b1;
                    emit_fail  = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    acc_next   = 64'(q_data.dig);
                    cnt_next   = cnt_bump;
                    phase_next = PH_DIGITS;
                end
            end
            PH_DIGITS: begin
                if (!dig_fit) begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    cnt_next = cnt_bump;
                    if (!ovf_eff) begin
                        if (acc_over) begin
                            ovf_next = 1'b1;
                        end else begin
                            acc_next = sum[63:0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (emit_fail) begin
            result.value    = '0;
            result.consumed = '0;
            result.status   = ST_NONE;
        end else begin
            if (ovf_eff) begin
                result.value = bound;
            end else if (neg_eff) begin
                result.value = 64'd0 - acc_eff;
            end else begin
                result.value = acc_eff;
            end
            result.consumed = cnt_eff;
            result.status   = ovf_eff ? ST_OVERFLOW : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            neg_reg   <= 1'b0;
            base_reg  <= BASE10;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            cnt_reg   <= '0;
        end else if (q_pop) begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            base_reg  <= base_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && emit) begin
            m_data_reg <= result;
        end
    end

endmodule

@@ sv/ascii_integer_parser.sv @@
// Top level of the ascii integer parser
// Takes one character per cycle while s_ready is high and returns one result per string:
// the signed 64-bit value, the count of characters consumed and a status. A character
// enters a two-entry queue in the cycle it transfers; the parse engine takes one queued
// character per cycle unless stalled, and its result appears in the output register the
// cycle after. The engine does one digit step (shift-add by the base and bound compare)
// per cycle, which sets the rate at one character per cycle. The engine stalls only when
// a result must be written while the output register still holds an untaken one.
// The user must see that base_mode is written only while idle; the block does not enforce it.
module ascii_integer_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  aip_pkg::aip_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output aip_pkg::aip_out_t m_data
);
    import aip_pkg::*;

`include "ascii_integer_parser_assert.svh"

    base_mode_t base_mode_reg;
    logic       push_valid;
    logic       push_ready;
    aip_cls_t   push_data;
    logic       q_valid;
    logic       q_pop;
    aip_cls_t   q_data;
    logic       out_zero;
    logic       out_at_limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_mode_reg <= MODE_AUTO;
        end else if (cfg_wr_en) begin
            base_mode_reg <= base_mode_t'(cfg_wr_data);
        end
    end

    aip_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    aip_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_data  (q_data)
    );

    aip_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .base_mode (base_mode_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign out_zero     = (m_data.value == 64'sd0) && (m_data.consumed == '0);
    assign out_at_limit = (m_data.value == 64'h7FFF_FFFF_FFFF_FFFF) ||
                          (m_data.value == 64'h8000_0000_0000_0000);

    `AIP_ASSERT_SAME(a_fail_zero, m_valid && m_data.status == ST_NONE, out_zero)
    `AIP_ASSERT_SAME(a_ovf_sat, m_valid && m_data.status == ST_OVERFLOW, out_at_limit)
    `AIP_ASSERT_SAME(a_ok_counted, m_valid && m_data.status != ST_NONE, m_data.consumed != '0)
    `AIP_ASSERT_SAME(a_full_has_head, !s_ready, q_valid)
    `AIP_ASSERT_NEXT(a_hold_result, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule
